>>> hdl/kji_pkg.sv
package kji_pkg;

  localparam int JOINTS       = 8;
  localparam int FRAME_DEPTH  = 16;
  localparam int INTERP_STEPS = 5;
  localparam int POS_W        = 16;
  localparam int TRIG_W       = 16;
  localparam int CMD_W        = 2;
  localparam int JOINT_W      = 3;

  localparam int JIDX_W  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int JCNT_W  = $clog2(JOINTS + 1);
  localparam int FPTR_W  = $clog2(FRAME_DEPTH);
  localparam int FCNT_W  = $clog2(FRAME_DEPTH + 1);
  localparam int FADDR_W = $clog2(FRAME_DEPTH * JOINTS);
  localparam int STEP_W  = (INTERP_STEPS > 1) ? $clog2(INTERP_STEPS) : 1;
  localparam int WGT_W   = $clog2(INTERP_STEPS + 1);

  // blend sum and reciprocal division by the step count
  localparam int MAG_W   = POS_W + $clog2(INTERP_STEPS);
  localparam int SUM_W   = MAG_W + 1;
  localparam int DIV_SH  = MAG_W + $clog2(INTERP_STEPS);
  localparam int RECIP   = ((2 ** DIV_SH) + INTERP_STEPS - 1) / INTERP_STEPS;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = MAG_W + RECIP_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_COMMIT = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMMIT,
    ST_TICK,
    ST_DRAIN
  } state_t;

endpackage

>>> hdl/kji_ram.sv
module kji_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/keyframe_joint_interpolator_unit.sv
// channel  direction  handshake            payload
// in       sink       in_valid / in_stall  command, joint_index, position, trigger_in
// out      source     out_valid / out_stall joint_out, drive_position, last_joint,
//                                           trigger_valid, trigger_out, overflow
//
// a commit copies one joint a cycle from the staging memory into the frame memory
// a tick gives JOINTS results, one per cycle while out_stall is low, through the
// frame and blend memory reads and the two blend stages
// synchronous reset clears pointers, step count, flag and valid bits; no clearing pass
// out_stall freezes the blend pipeline; the output register holds a stalled transaction
module keyframe_joint_interpolator_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [kji_pkg::CMD_W-1:0]        command,
  input  logic [kji_pkg::JOINT_W-1:0]      joint_index,
  input  logic signed [kji_pkg::POS_W-1:0] position,
  input  logic signed [kji_pkg::TRIG_W-1:0] trigger_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [kji_pkg::JOINT_W-1:0]      joint_out,
  output logic signed [kji_pkg::POS_W-1:0] drive_position,
  output logic                             last_joint,
  output logic                             trigger_valid,
  output logic signed [kji_pkg::TRIG_W-1:0] trigger_out,
  output logic                             overflow
);

  localparam int JW = kji_pkg::JIDX_W;
  localparam int CW = kji_pkg::JCNT_W;
  localparam int PW = kji_pkg::FPTR_W;
  localparam int NW = kji_pkg::FCNT_W;
  localparam int AW = kji_pkg::FADDR_W;
  localparam int XW = kji_pkg::POS_W;

  kji_pkg::state_t state, state_next;

  logic [CW-1:0]           jc;
  logic [PW-1:0]           rd;
  logic [NW-1:0]           cnt;
  logic [kji_pkg::STEP_W-1:0] step;
  logic                    ovf;
  logic                    pop;
  logic [kji_pkg::JOINTS-1:0] st_valid;
  logic [kji_pkg::JOINTS-1:0] pt_valid;
  logic                    stv_q;

  logic                    s1_valid;
  logic [JW-1:0]           s1_j;
  logic                    s1_ptv;
  logic                    s2_valid;
  logic [JW-1:0]           s2_j;
  logic                    s2_neg;
  logic [kji_pkg::MAG_W-1:0] s2_mag;

  logic in_acc, is_write, is_commit, is_tick, wr_ok;
  logic full, empty, tick_go, commit_go;
  logic adv, issue, last_issue, drained, tick_done, commit_done;
  logic [PW:0]   wr_sum;
  logic [PW-1:0] wr, rd_next;

  logic          st_we, st_re;
  logic [JW-1:0] st_waddr, st_raddr;
  logic [XW-1:0] st_rdata;
  logic          f_we, f_re;
  logic [AW-1:0] f_waddr, f_raddr;
  logic [XW-1:0] f_wdata, f_rdata;
  logic          t_we, t_re;
  logic [PW-1:0] t_waddr, t_raddr;
  logic [kji_pkg::TRIG_W-1:0] t_wdata, t_rdata;
  logic          pt_we, pt_re;
  logic [JW-1:0] pt_waddr, pt_raddr;
  logic [2*XW-1:0] pt_wdata, pt_rdata;

  logic signed [XW-1:0] old_prev, old_tgt, new_prev, new_tgt;
  logic [kji_pkg::WGT_W-1:0] w0, w1;
  logic signed [kji_pkg::SUM_W-1:0] sum;
  logic [kji_pkg::SUM_W-1:0] sum_abs;
  logic [kji_pkg::PROD_W-1:0] prod;
  logic [XW-1:0] quo, res;
  logic tv;

  function automatic logic [AW-1:0] frame_addr(input logic [PW-1:0] p,
                                               input logic [JW-1:0] j);
    frame_addr = AW'(AW'(p) * AW'(kji_pkg::JOINTS)) + AW'(j);
  endfunction

  assign in_stall  = (state != kji_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign is_write  = in_acc && (command == kji_pkg::CMD_WRITE);
  assign is_commit = in_acc && (command == kji_pkg::CMD_COMMIT);
  assign is_tick   = in_acc && (command == kji_pkg::CMD_TICK);
  assign wr_ok     = 32'(joint_index) < kji_pkg::JOINTS;

  assign full      = (cnt == NW'(kji_pkg::FRAME_DEPTH));
  assign empty     = (cnt == '0);
  assign tick_go   = is_tick && !((step == '0) && empty);
  assign commit_go = is_commit && !full;

  assign adv         = !out_valid || !out_stall;
  assign issue       = (state == kji_pkg::ST_TICK) && adv;
  assign last_issue  = issue && (jc == CW'(kji_pkg::JOINTS - 1));
  assign drained     = !s1_valid && !s2_valid;
  assign tick_done   = (state == kji_pkg::ST_DRAIN) && drained;
  assign commit_done = (state == kji_pkg::ST_COMMIT) && (jc == CW'(kji_pkg::JOINTS));

  assign wr_sum  = {1'b0, rd} + (PW + 1)'(cnt);
  assign wr      = (wr_sum >= (PW + 1)'(kji_pkg::FRAME_DEPTH)) ?
                   PW'(wr_sum - (PW + 1)'(kji_pkg::FRAME_DEPTH)) : PW'(wr_sum);
  assign rd_next = (rd == PW'(kji_pkg::FRAME_DEPTH - 1)) ? '0 : rd + 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      kji_pkg::ST_IDLE: begin
        if (tick_go) begin
          state_next = kji_pkg::ST_TICK;
        end else if (commit_go) begin
          state_next = kji_pkg::ST_COMMIT;
        end
      end
      kji_pkg::ST_COMMIT: begin
        if (commit_done) begin
          state_next = kji_pkg::ST_IDLE;
        end
      end
      kji_pkg::ST_TICK: begin
        if (last_issue) begin
          state_next = kji_pkg::ST_DRAIN;
        end
      end
      kji_pkg::ST_DRAIN: begin
        if (drained) begin
          state_next = kji_pkg::ST_IDLE;
        end
      end
      default: state_next = kji_pkg::ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    st_we    = is_write && wr_ok;
    st_waddr = JW'(joint_index);
    st_re    = (state == kji_pkg::ST_COMMIT) && (jc < CW'(kji_pkg::JOINTS));
    st_raddr = JW'(jc);

    f_we     = (state == kji_pkg::ST_COMMIT) && (jc != '0);
    f_waddr  = frame_addr(wr, JW'(jc - CW'(1)));
    f_wdata  = stv_q ? st_rdata : '0;
    f_re     = issue;
    f_raddr  = frame_addr(rd, JW'(jc));

    t_we     = commit_go;
    t_waddr  = wr;
    t_wdata  = trigger_in;
    t_re     = tick_go;
    t_raddr  = rd;

    pt_we    = s1_valid && adv && pop;
    pt_waddr = s1_j;
    pt_wdata = {new_prev, new_tgt};
    pt_re    = issue;
    pt_raddr = JW'(jc);
  end

  kji_ram #(.WIDTH(XW), .DEPTH(kji_pkg::JOINTS)) u_staging (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(position),
    .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
  );

  kji_ram #(.WIDTH(XW), .DEPTH(kji_pkg::FRAME_DEPTH * kji_pkg::JOINTS)) u_frames (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(f_re), .raddr(f_raddr), .rdata(f_rdata)
  );

  kji_ram #(.WIDTH(kji_pkg::TRIG_W), .DEPTH(kji_pkg::FRAME_DEPTH)) u_triggers (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
  );

  kji_ram #(.WIDTH(2 * XW), .DEPTH(kji_pkg::JOINTS)) u_prev_target (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .re(pt_re), .raddr(pt_raddr), .rdata(pt_rdata)
  );

  // blend stage one: shift frames on a pop, weighted sum
  always_comb begin
    old_prev = s1_ptv ? $signed(pt_rdata[2*XW-1:XW]) : '0;
    old_tgt  = s1_ptv ? $signed(pt_rdata[XW-1:0]) : '0;
    new_prev = pop ? old_tgt : old_prev;
    new_tgt  = pop ? $signed(f_rdata) : old_tgt;
    w1       = kji_pkg::WGT_W'(step);
    w0       = kji_pkg::WGT_W'(kji_pkg::INTERP_STEPS) - w1;
    sum      = kji_pkg::SUM_W'(new_prev) * kji_pkg::SUM_W'($signed({1'b0, w0}))
             + kji_pkg::SUM_W'(new_tgt) * kji_pkg::SUM_W'($signed({1'b0, w1}));
    sum_abs  = sum[kji_pkg::SUM_W-1] ? kji_pkg::SUM_W'(-sum) : kji_pkg::SUM_W'(sum);
  end

  // blend stage two: divide by reciprocal, truncate toward zero
  always_comb begin
    prod = kji_pkg::PROD_W'(s2_mag) * kji_pkg::PROD_W'(kji_pkg::RECIP);
    quo  = XW'(prod >> kji_pkg::DIV_SH);
    res  = s2_neg ? XW'(-quo) : quo;
    tv   = pop && (t_rdata != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kji_pkg::ST_IDLE;
      jc        <= '0;
      rd        <= '0;
      cnt       <= '0;
      step      <= '0;
      ovf       <= 1'b0;
      pop       <= 1'b0;
      st_valid  <= '0;
      pt_valid  <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (st_we) begin
        st_valid[JW'(joint_index)] <= 1'b1;
      end
      if (is_commit && full) begin
        ovf <= 1'b1;
      end
      if (tick_go) begin
        pop <= (step == '0);
      end
      if (tick_go || commit_go) begin
        jc <= '0;
      end else if ((state == kji_pkg::ST_COMMIT) && !commit_done) begin
        jc <= jc + 1'b1;
      end else if (issue) begin
        jc <= jc + 1'b1;
      end
      if (commit_done) begin
        cnt <= cnt + 1'b1;
      end
      if (tick_done) begin
        step <= (step == kji_pkg::STEP_W'(kji_pkg::INTERP_STEPS - 1)) ? '0 : step + 1'b1;
        if (pop) begin
          rd  <= rd_next;
          cnt <= cnt - 1'b1;
        end
      end
      if (pt_we) begin
        pt_valid[s1_j] <= 1'b1;
      end
      if (adv) begin
        s1_valid  <= issue;
        s2_valid  <= s1_valid;
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_re) begin
      stv_q <= st_valid[JW'(jc)];
    end
    if (issue) begin
      s1_j   <= JW'(jc);
      s1_ptv <= pt_valid[JW'(jc)];
    end
    if (adv && s1_valid) begin
      s2_j   <= s1_j;
      s2_neg <= sum[kji_pkg::SUM_W-1];
      s2_mag <= sum_abs[kji_pkg::MAG_W-1:0];
    end
    if (adv && s2_valid) begin
      joint_out      <= kji_pkg::JOINT_W'(s2_j);
      drive_position <= res;
      last_joint     <= (s2_j == JW'(kji_pkg::JOINTS - 1));
      trigger_valid  <= tv;
      trigger_out    <= tv ? t_rdata : '0;
      overflow       <= ovf;
    end
  end

endmodule

>>> hdl/kji_checker.sv
module kji_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [kji_pkg::CMD_W-1:0]        command,
  input logic [kji_pkg::JOINT_W-1:0]      joint_index,
  input logic signed [kji_pkg::POS_W-1:0] position,
  input logic signed [kji_pkg::TRIG_W-1:0] trigger_in,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [kji_pkg::JOINT_W-1:0]      joint_out,
  input logic signed [kji_pkg::POS_W-1:0] drive_position,
  input logic                             last_joint,
  input logic                             trigger_valid,
  input logic signed [kji_pkg::TRIG_W-1:0] trigger_out,
  input logic                             overflow
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive_position) && $stable(joint_out))
    else $error("stalled output changed");

  // more joints still to come keep the input side busy
  a_busy_mid_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_joint |=> in_stall)
    else $error("input taken in the middle of a tick");

  // overflow is sticky
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |=> !out_valid || overflow)
    else $error("overflow flag cleared");

  a_trig_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !trigger_valid |-> trigger_out == '0)
    else $error("trigger tag without trigger_valid");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_joint |-> joint_out == kji_pkg::JOINT_W'(kji_pkg::JOINTS - 1))
    else $error("last marker on wrong joint");

endmodule

bind keyframe_joint_interpolator_unit kji_checker u_kji_checker (.*);
